>>> hdl/sobb_pkg.sv
// ----------------------------------------------------------------------------
// sobb_pkg
// Shared types, constants and fixed point helpers of the swept box test.
// ----------------------------------------------------------------------------
package sobb_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int DIV_STEPS  = FRAC_BITS + 1;
  localparam int TW         = FRAC_BITS + 3;
  localparam int XF_STG     = 4;
  localparam int AX_STG     = DIV_STEPS + 2;
  localparam int NSTG       = XF_STG + AX_STG + 1;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIME_STEP = 1'b0,
    CFG_ZERO_THR  = 1'b1
  } cfg_idx_t;

  localparam logic [31:0] TIME_STEP_RST = 32'd1092;
  localparam logic [15:0] ZERO_THR_RST  = 16'd1;

  typedef logic signed [31:0]   q_t;
  typedef logic signed [TW-1:0] tq_t;

  localparam tq_t T_ONE = tq_t'(1) <<< FRAC_BITS;

  typedef struct packed {
    q_t px, py, c, s, cx, cy, ex, ey;
  } box_t;

  typedef struct packed {
    q_t center, wide, point, travel;
  } axis_t;

  localparam logic signed [35:0] S36_MAX = 36'sd2147483647;
  localparam logic signed [35:0] S36_MIN = -36'sd2147483648;
  localparam logic signed [65:0] S66_MAX = 66'sd2147483647;
  localparam logic signed [65:0] S66_MIN = -66'sd2147483648;

  function automatic q_t sat32(input logic signed [35:0] v);
    if (v > S36_MAX) return q_t'(S36_MAX);
    if (v < S36_MIN) return q_t'(S36_MIN);
    return q_t'(v);
  endfunction

  // floored product, saturated to 32 bits
  function automatic q_t qmul(input logic signed [32:0] a, input logic signed [32:0] b);
    logic signed [65:0] p;
    logic signed [65:0] f;
    p = 66'(a) * 66'(b);
    f = p >>> FRAC_BITS;
    if (f > S66_MAX) return q_t'(S66_MAX);
    if (f < S66_MIN) return q_t'(S66_MIN);
    return q_t'(f);
  endfunction

  function automatic logic signed [35:0] ext36(input q_t x);
    return 36'(x);
  endfunction

  function automatic logic signed [35:0] mag36(input q_t x);
    return (x < 0) ? -ext36(x) : ext36(x);
  endfunction

  function automatic box_t unpack(input logic [63:0] pos, input logic [63:0] rot,
                                  input logic [63:0] cen, input logic [63:0] ext);
    box_t b;
    b.px = q_t'(pos[63:32]); b.py = q_t'(pos[31:0]);
    b.c  = q_t'(rot[63:32]); b.s  = q_t'(rot[31:0]);
    b.cx = q_t'(cen[63:32]); b.cy = q_t'(cen[31:0]);
    b.ex = q_t'(ext[63:32]); b.ey = q_t'(ext[31:0]);
    return b;
  endfunction

endpackage

>>> hdl/sobb_in_if.sv
// ----------------------------------------------------------------------------
// sobb_in_if
// Input channel: one box pair item per handshake.
// ----------------------------------------------------------------------------
interface sobb_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] a_position;
  logic [63:0] a_rotation;
  logic [63:0] a_center;
  logic [63:0] a_extent;
  logic [63:0] b_position;
  logic [63:0] b_rotation;
  logic [63:0] b_center;
  logic [63:0] b_extent;
  logic [63:0] relative_velocity;

  modport source (output valid, a_position, a_rotation, a_center, a_extent,
                  b_position, b_rotation, b_center, b_extent, relative_velocity,
                  input ready);
  modport sink (input valid, a_position, a_rotation, a_center, a_extent,
                b_position, b_rotation, b_center, b_extent, relative_velocity,
                output ready);
endinterface

>>> hdl/sobb_out_if.sv
// ----------------------------------------------------------------------------
// sobb_out_if
// Result channel: one hit flag per item.
// ----------------------------------------------------------------------------
interface sobb_out_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink (input valid, hit, output ready);
endinterface

>>> hdl/sobb_xform.sv
// ----------------------------------------------------------------------------
// sobb_xform
// Four-stage transform of the partner box and velocity into the frame box.
// ----------------------------------------------------------------------------
module sobb_xform
  import sobb_pkg::*;
(
  input  logic              clk,
  input  logic [XF_STG-1:0] en,
  input  box_t              o,
  input  box_t              p,
  input  q_t                vx,
  input  q_t                vy,
  input  logic [31:0]       dt,
  output axis_t             ax_x,
  output axis_t             ax_y
);

  logic signed [32:0] dt33;
  assign dt33 = $signed({1'b0, dt});

  // stage 1: products of the raw fields
  box_t s1_o, s1_p;
  q_t mcc, mss, msc, mcs, pccx, pscy, pscx, pccy, vcx, vsy, vcy, vsx;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_o <= o;
      s1_p <= p;
      mcc  <= qmul(33'(o.c), 33'(p.c));
      mss  <= qmul(33'(o.s), 33'(p.s));
      msc  <= qmul(33'(o.s), 33'(p.c));
      mcs  <= qmul(33'(o.c), 33'(p.s));
      pccx <= qmul(33'(p.c), 33'(p.cx));
      pscy <= qmul(33'(p.s), 33'(p.cy));
      pscx <= qmul(33'(p.s), 33'(p.cx));
      pccy <= qmul(33'(p.c), 33'(p.cy));
      vcx  <= qmul(33'(o.c), 33'(vx));
      vsy  <= qmul(33'(o.s), 33'(vy));
      vcy  <= qmul(33'(o.c), 33'(vy));
      vsx  <= qmul(33'(o.s), 33'(vx));
    end
  end

  // stage 2: rotation matrix, partner offset, rotated velocity
  box_t s2_o;
  q_t s2_pex, s2_pey, m00, m01, m10, dx, dy, rvx, rvy;
  q_t wx, wy;

  always_comb begin
    wx = sat32(ext36(pccx) - ext36(pscy) + ext36(s1_p.px));
    wy = sat32(ext36(pscx) + ext36(pccy) + ext36(s1_p.py));
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_o   <= s1_o;
      s2_pex <= s1_p.ex;
      s2_pey <= s1_p.ey;
      m00    <= sat32(ext36(mcc) + ext36(mss));
      m01    <= sat32(ext36(msc) - ext36(mcs));
      m10    <= sat32(ext36(mcs) - ext36(msc));
      dx     <= sat32(ext36(wx) - ext36(s1_o.px));
      dy     <= sat32(ext36(wy) - ext36(s1_o.py));
      rvx    <= sat32(ext36(vcx) + ext36(vsy));
      rvy    <= sat32(ext36(vcy) - ext36(vsx));
    end
  end

  // stage 3: projected extents, local offset, travel
  q_t s3_ex, s3_ey, s3_cx, s3_cy;
  q_t e00, e01, e10, e11, lcx, lsy, lcy, lsx, trx, tr_y;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_ex <= s2_o.ex;
      s3_ey <= s2_o.ey;
      s3_cx <= s2_o.cx;
      s3_cy <= s2_o.cy;
      e00   <= qmul(33'(m00), 33'(s2_pex));
      e01   <= qmul(33'(m01), 33'(s2_pey));
      e10   <= qmul(33'(m10), 33'(s2_pex));
      e11   <= qmul(33'(m00), 33'(s2_pey));
      lcx   <= qmul(33'(s2_o.c), 33'(dx));
      lsy   <= qmul(33'(s2_o.s), 33'(dy));
      lcy   <= qmul(33'(s2_o.c), 33'(dy));
      lsx   <= qmul(33'(s2_o.s), 33'(dx));
      trx   <= qmul(33'(rvx), dt33);
      tr_y  <= qmul(33'(rvy), dt33);
    end
  end

  // stage 4: widened extents and local point
  always_ff @(posedge clk) begin
    if (en[3]) begin
      ax_x.center <= s3_cx;
      ax_x.wide   <= sat32(ext36(s3_ex) + mag36(e00) + mag36(e01));
      ax_x.point  <= sat32(ext36(lcx) + ext36(lsy));
      ax_x.travel <= trx;
      ax_y.center <= s3_cy;
      ax_y.wide   <= sat32(ext36(s3_ey) + mag36(e10) + mag36(e11));
      ax_y.point  <= sat32(ext36(lcy) - ext36(lsx));
      ax_y.travel <= tr_y;
    end
  end

endmodule

>>> hdl/sobb_axis.sv
// ----------------------------------------------------------------------------
// sobb_axis
// Entry/exit times of one axis through a pipelined restoring divider.
// ----------------------------------------------------------------------------
module sobb_axis
  import sobb_pkg::*;
(
  input  logic              clk,
  input  logic [AX_STG-1:0] en,
  input  axis_t             ax,
  input  logic [15:0]       thr,
  output logic              pass,
  output tq_t               t_in,
  output tq_t               t_out
);

  localparam int RW = 34;

  typedef struct packed {
    logic fail;
    logic stat;
    logic stat_pass;
    logic neg_e;
    logic neg_x;
    logic big_e;
    logic big_x;
  } ctl_t;

  ctl_t                 ctl [DIV_STEPS+1];
  logic [31:0]          tm  [DIV_STEPS+1];
  logic [RW-1:0]        re  [DIV_STEPS+1];
  logic [RW-1:0]        rx  [DIV_STEPS+1];
  logic [DIV_STEPS-1:0] qe  [DIV_STEPS+1];
  logic [DIV_STEPS-1:0] qx  [DIV_STEPS+1];

  // prep: interval ends, distances and magnitudes
  logic signed [32:0] st, nd, t33, pt33;
  logic signed [33:0] de, dx;
  logic [RW-1:0]      me, mx, t2;
  logic [31:0]        tmag;
  ctl_t               c0;

  always_comb begin
    st   = 33'(ax.center) - 33'(ax.wide);
    nd   = 33'(ax.center) + 33'(ax.wide);
    pt33 = 33'(ax.point);
    de   = 34'(st) - 34'(pt33);
    dx   = 34'(nd) - 34'(pt33);
    me   = (de < 0) ? $unsigned(-de) : $unsigned(de);
    mx   = (dx < 0) ? $unsigned(-dx) : $unsigned(dx);
    t33  = 33'(ax.travel);
    tmag = (t33 < 0) ? 32'(-t33) : 32'(t33);
    t2   = {1'b0, tmag, 1'b0};
    c0.fail      = (ax.wide <= 0);
    c0.stat      = (tmag <= {16'b0, thr});
    c0.stat_pass = !(pt33 < st || pt33 > nd);
    c0.neg_e     = de[33] ^ ax.travel[31];
    c0.neg_x     = dx[33] ^ ax.travel[31];
    // quotient at or above twice the unit time
    c0.big_e     = (me >= t2);
    c0.big_x     = (mx >= t2);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ctl[0] <= c0;
      tm[0]  <= tmag;
      re[0]  <= me;
      rx[0]  <= mx;
      qe[0]  <= '0;
      qx[0]  <= '0;
    end
  end

  // one quotient bit per stage
  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
    logic [RW-1:0] ri_e, ri_x, tt;
    logic          be, bx;

    always_comb begin
      ri_e = (k == 1) ? re[k-1] : (re[k-1] << 1);
      ri_x = (k == 1) ? rx[k-1] : (rx[k-1] << 1);
      tt   = {2'b0, tm[k-1]};
      be   = (ri_e >= tt);
      bx   = (ri_x >= tt);
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        ctl[k] <= ctl[k-1];
        tm[k]  <= tm[k-1];
        re[k]  <= be ? (ri_e - tt) : ri_e;
        rx[k]  <= bx ? (ri_x - tt) : ri_x;
        qe[k]  <= {qe[k-1][DIV_STEPS-2:0], be};
        qx[k]  <= {qx[k-1][DIV_STEPS-2:0], bx};
      end
    end
  end

  // finish: signs, ordering and the pass test
  ctl_t           cf;
  logic [DIV_STEPS:0] mq_e, mq_x;
  tq_t            ve, vx_t, lo, hi;
  logic           p_f;
  tq_t            ti_f, to_f;

  always_comb begin
    cf   = ctl[DIV_STEPS];
    mq_e = cf.big_e ? {1'b1, {DIV_STEPS{1'b0}}} : {1'b0, qe[DIV_STEPS]};
    mq_x = cf.big_x ? {1'b1, {DIV_STEPS{1'b0}}} : {1'b0, qx[DIV_STEPS]};
    ve   = cf.neg_e ? -tq_t'({1'b0, mq_e}) : tq_t'({1'b0, mq_e});
    vx_t = cf.neg_x ? -tq_t'({1'b0, mq_x}) : tq_t'({1'b0, mq_x});
    lo   = (ve > vx_t) ? vx_t : ve;
    hi   = (ve > vx_t) ? ve : vx_t;
    if (cf.stat) begin
      p_f  = cf.stat_pass;
      ti_f = '0;
      to_f = T_ONE;
    end else begin
      p_f  = !(lo >= T_ONE || hi <= 0);
      ti_f = lo;
      to_f = hi;
    end
    if (cf.fail) p_f = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (en[AX_STG-1]) begin
      pass  <= p_f;
      t_in  <= ti_f;
      t_out <= to_f;
    end
  end

endmodule

>>> hdl/swept_obb_2d_collision_test_unit.sv
// ----------------------------------------------------------------------------
// swept_obb_2d_collision_test_unit
// Swept separating-axis overlap test of two rotated 2D boxes per item.
// ----------------------------------------------------------------------------
// usage:
//   boxes  : box pair items (valid/ready), one accepted per cycle at most
//   result : one hit flag per accepted item, in order
//   cfg_*  : register writes (time step, zero travel threshold); the user
//            must write them only while idle, the block does not enforce it;
//            index 0 is the time step, index 1 the threshold
// pipeline: 4 transform stages, 1 prep stage, one divider stage per quotient
//   bit (FRAC_BITS + 1, Q16.16 operands), 1 finish stage and 1 merge stage
// throughput: one item per cycle unless the result side stalls; the eight
//   per-axis dividers are pipelined and every stage has its own valid bit
// reset: clears all valid bits and restores the register defaults
// stall: a waiting result holds in the output stage; empty stages upstream
//   keep filling, so nothing is dropped or repeated
// ----------------------------------------------------------------------------
module swept_obb_2d_collision_test_unit
  import sobb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  sobb_in_if.sink               boxes,
  sobb_out_if.source            result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [31:0] time_step;
  logic [15:0] zero_travel_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step             <= TIME_STEP_RST;
      zero_travel_threshold <= ZERO_THR_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_TIME_STEP: time_step             <= cfg_data;
        CFG_ZERO_THR:  zero_travel_threshold <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // stage enables: a stage loads when empty or when the next one moves
  logic [NSTG-1:0] v, en;

  always_comb begin
    en[NSTG-1] = !v[NSTG-1] || result.ready;
    for (int k = NSTG - 2; k >= 0; k--) en[k] = !v[k] || en[k+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= boxes.valid;
      for (int k = 1; k < NSTG; k++) if (en[k]) v[k] <= v[k-1];
    end
  end

  assign boxes.ready = en[0];

  box_t box_a, box_b;
  q_t   vx, vy, nvx, nvy;

  always_comb begin
    box_a = unpack(boxes.a_position, boxes.a_rotation, boxes.a_center, boxes.a_extent);
    box_b = unpack(boxes.b_position, boxes.b_rotation, boxes.b_center, boxes.b_extent);
    vx    = q_t'(boxes.relative_velocity[63:32]);
    vy    = q_t'(boxes.relative_velocity[31:0]);
    nvx   = sat32(-ext36(vx));
    nvy   = sat32(-ext36(vy));
  end

  axis_t ax [4];

  // side 0: a in the frame of b, side 1: b in the frame of a
  sobb_xform u_xf0 (
    .clk(clk), .en(en[XF_STG-1:0]), .o(box_b), .p(box_a), .vx(vx), .vy(vy),
    .dt(time_step), .ax_x(ax[0]), .ax_y(ax[1])
  );

  sobb_xform u_xf1 (
    .clk(clk), .en(en[XF_STG-1:0]), .o(box_a), .p(box_b), .vx(nvx), .vy(nvy),
    .dt(time_step), .ax_x(ax[2]), .ax_y(ax[3])
  );

  logic [3:0] pass;
  tq_t        t_in  [4];
  tq_t        t_out [4];

  for (genvar i = 0; i < 4; i++) begin : g_axis
    sobb_axis u_axis (
      .clk(clk), .en(en[XF_STG +: AX_STG]), .ax(ax[i]), .thr(zero_travel_threshold),
      .pass(pass[i]), .t_in(t_in[i]), .t_out(t_out[i])
    );
  end

  // merge the four intervals
  tq_t  ti, to;
  logic hit_next;
  logic hit;

  always_comb begin
    ti = '0;
    to = T_ONE;
    for (int i = 0; i < 4; i++) begin
      if (t_in[i] > ti)  ti = t_in[i];
      if (t_out[i] < to) to = t_out[i];
    end
    hit_next = (&pass) && (ti < to);
  end

  always_ff @(posedge clk) begin
    if (en[NSTG-1]) hit <= hit_next;
  end

  assign result.valid = v[NSTG-1];
  assign result.hit   = hit;

endmodule

>>> hdl/sobb_chk.sv
// ----------------------------------------------------------------------------
// sobb_chk
// Port-level checks of the swept box test unit, bound to the top level.
// ----------------------------------------------------------------------------
module sobb_chk (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic hit
);

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // a free output stage lets the input side move
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled with output free");

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

  a_hit_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(hit))
    else $error("hit changed while stalled");

endmodule

bind swept_obb_2d_collision_test_unit sobb_chk u_sobb_chk (
  .clk(clk), .rst(rst), .in_ready(boxes.ready),
  .out_valid(result.valid), .out_ready(result.ready), .hit(result.hit)
);

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Streams box pair items through the swept box collision test, predicts the
// hit flag of each accepted item and checks every result in order, over
// several time step and threshold settings with random idling on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 40;
  localparam longint Q_ONE      = longint'(1) << sobb_pkg::FRAC_BITS;

  typedef struct {
    logic [63:0] a_pos, a_rot, a_cen, a_ext, b_pos, b_rot, b_cen, b_ext, rel_vel;
  } pair_item_t;

  typedef struct {
    longint px, py, c, s, cx, cy, ex, ey;
  } box_m_t;

  class scoreboard;
    longint unsigned time_step = 1092;
    longint unsigned zero_thr  = 1;
    bit hit_q[$];
    int n_in;
    int n_err;

    function longint sat(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // floored fixed point product
    function longint qm(longint a, longint b);
      longint p;
      p = a * b;
      return sat(p >>> sobb_pkg::FRAC_BITS);
    endfunction

    function longint mag(longint v);
      return v < 0 ? -v : v;
    endfunction

    function longint hi(logic [63:0] w);
      return longint'($signed(w[63:32]));
    endfunction

    function longint lo(logic [63:0] w);
      return longint'($signed(w[31:0]));
    endfunction

    function box_m_t to_box(logic [63:0] p, logic [63:0] r, logic [63:0] c,
                            logic [63:0] e);
      box_m_t b;
      b.px = hi(p); b.py = lo(p); b.c = hi(r); b.s = lo(r);
      b.cx = hi(c); b.cy = lo(c); b.ex = hi(e); b.ey = lo(e);
      return b;
    endfunction

    function bit axis_ok(longint center, longint wide, longint point, longint travel,
                         inout longint t_in, inout longint t_out);
      longint start, stop, ent, ext, tmp;
      if (wide <= 0) return 0;
      start = center - wide;
      stop  = center + wide;
      if (mag(travel) <= longint'(zero_thr)) begin
        if (point < start || point > stop) return 0;
        ent = 0;
        ext = Q_ONE;
      end else begin
        ent = ((start - point) * Q_ONE) / travel;
        ext = ((stop - point) * Q_ONE) / travel;
        if (ent > ext) begin
          tmp = ent; ent = ext; ext = tmp;
        end
        if (ent >= Q_ONE || ext <= 0) return 0;
      end
      if (ent > t_in) t_in = ent;
      if (ext < t_out) t_out = ext;
      return 1;
    endfunction

    // partner p seen from frame box o, (vx, vy) is p's velocity relative to o
    function bit frame_ok(box_m_t o, box_m_t p, longint vx, longint vy,
                          inout longint t_in, inout longint t_out);
      longint dt, m00, m01, m10, wide_x, wide_y, wx, wy, dx, dy, lx, ly, rvx, rvy;
      dt = longint'(time_step);
      m00 = sat(qm(o.c, p.c) + qm(o.s, p.s));
      m01 = sat(qm(o.s, p.c) - qm(o.c, p.s));
      m10 = sat(qm(o.c, p.s) - qm(o.s, p.c));
      wide_x = sat(o.ex + mag(qm(m00, p.ex)) + mag(qm(m01, p.ey)));
      wide_y = sat(o.ey + mag(qm(m10, p.ex)) + mag(qm(m00, p.ey)));
      wx = sat(qm(p.c, p.cx) - qm(p.s, p.cy) + p.px);
      wy = sat(qm(p.s, p.cx) + qm(p.c, p.cy) + p.py);
      dx = sat(wx - o.px);
      dy = sat(wy - o.py);
      lx = sat(qm(o.c, dx) + qm(o.s, dy));
      ly = sat(qm(o.c, dy) - qm(o.s, dx));
      rvx = sat(qm(o.c, vx) + qm(o.s, vy));
      rvy = sat(qm(o.c, vy) - qm(o.s, vx));
      if (!axis_ok(o.cx, wide_x, lx, qm(rvx, dt), t_in, t_out)) return 0;
      return axis_ok(o.cy, wide_y, ly, qm(rvy, dt), t_in, t_out);
    endfunction

    function bit predict_hit(pair_item_t it);
      box_m_t a, b;
      longint vx, vy, t_in, t_out;
      a = to_box(it.a_pos, it.a_rot, it.a_cen, it.a_ext);
      b = to_box(it.b_pos, it.b_rot, it.b_cen, it.b_ext);
      vx = hi(it.rel_vel);
      vy = lo(it.rel_vel);
      t_in = 0;
      t_out = Q_ONE;
      if (!frame_ok(b, a, vx, vy, t_in, t_out)) return 0;
      if (!frame_ok(a, b, sat(-vx), sat(-vy), t_in, t_out)) return 0;
      return t_in < t_out;
    endfunction

    function void note_pair(pair_item_t it);
      hit_q = {hit_q, predict_hit(it)};
      n_in++;
    endfunction

    function void check_hit(logic hit);
      bit want;
      if (hit_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected result: hit=%b", hit);
        return;
      end
      want = hit_q.pop_front();
      if (hit !== want) begin
        n_err++;
        if (n_err <= 10) $display("hit mismatch: expected %b actual %b", want, hit);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [sobb_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [sobb_pkg::CFG_DATA_W-1:0] cfg_data;

  sobb_in_if  boxes_if();
  sobb_out_if result_if();

  scoreboard sb = new();

  int idle_cycles;
  int hold_left;
  bit hold_done;
  int stall_cyc;

  swept_obb_2d_collision_test_unit dut (
    .clk(clk), .rst(rst), .boxes(boxes_if), .result(result_if),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // result side: stall pattern plus one long hold-off once 300 items are in
  always @(posedge clk) begin
    stall_cyc++;
    if (hold_left > 0) begin
      hold_left--;
      result_if.ready <= 1'b0;
    end else if (!hold_done && sb.n_in >= 300) begin
      hold_done = 1;
      hold_left = 400;
      result_if.ready <= 1'b0;
    end else if ((stall_cyc / 64) % 3 == 0) begin
      result_if.ready <= 1'b1;
    end else begin
      result_if.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_if.valid && result_if.ready) sb.check_hit(result_if.hit);
  end

  always @(posedge clk) begin
    if ((boxes_if.valid && boxes_if.ready) || (result_if.valid && result_if.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [63:0] pack2(int x, int y);
    return {x[31:0], y[31:0]};
  endfunction

  function automatic int rnd_q(int lo_v, int hi_v);
    return lo_v + int'($urandom_range(0, hi_v - lo_v));
  endfunction

  function automatic logic [63:0] rnd64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] rnd_rot();
    real ang;
    ang = $urandom_range(0, 6283) / 1000.0;
    return pack2($rtoi($cos(ang) * 65536.0), $rtoi($sin(ang) * 65536.0));
  endfunction

  // plausible scene: nearby boxes, positive extents, mostly moderate speed
  function automatic pair_item_t scene_pair();
    pair_item_t it;
    int vr;
    vr = ($urandom_range(0, 3) == 0) ? 32'h3fff_ffff : 65536 * 400;
    it.a_pos = pack2(rnd_q(-262144, 262144), rnd_q(-262144, 262144));
    it.b_pos = pack2(rnd_q(-262144, 262144), rnd_q(-262144, 262144));
    it.a_rot = rnd_rot();
    it.b_rot = rnd_rot();
    it.a_cen = pack2(rnd_q(-32768, 32768), rnd_q(-32768, 32768));
    it.b_cen = pack2(rnd_q(-32768, 32768), rnd_q(-32768, 32768));
    it.a_ext = pack2(rnd_q(8192, 131072), rnd_q(8192, 131072));
    it.b_ext = pack2(rnd_q(8192, 131072), rnd_q(8192, 131072));
    it.rel_vel = pack2(rnd_q(-vr, vr), rnd_q(-vr, vr));
    if ($urandom_range(0, 7) == 0) it.rel_vel = '0;
    return it;
  endfunction

  function automatic pair_item_t noise_pair();
    pair_item_t it;
    it.a_pos = rnd64(); it.a_rot = rnd64(); it.a_cen = rnd64(); it.a_ext = rnd64();
    it.b_pos = rnd64(); it.b_rot = rnd64(); it.b_cen = rnd64(); it.b_ext = rnd64();
    it.rel_vel = rnd64();
    return it;
  endfunction

  task automatic send_pair(pair_item_t it);
    boxes_if.valid <= 1'b1;
    boxes_if.a_position <= it.a_pos;
    boxes_if.a_rotation <= it.a_rot;
    boxes_if.a_center <= it.a_cen;
    boxes_if.a_extent <= it.a_ext;
    boxes_if.b_position <= it.b_pos;
    boxes_if.b_rotation <= it.b_rot;
    boxes_if.b_center <= it.b_cen;
    boxes_if.b_extent <= it.b_ext;
    boxes_if.relative_velocity <= it.rel_vel;
    do @(posedge clk); while (!boxes_if.ready);
    sb.note_pair(it);
  endtask

  // burst of items, then a random gap
  task automatic send_stream(pair_item_t it, inout int burst_left);
    send_pair(it);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      boxes_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(0, 20);
    end
  endtask

  task automatic write_reg(sobb_pkg::cfg_idx_t idx, logic [31:0] value);
    boxes_if.valid <= 1'b0;
    while (sb.hit_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == sobb_pkg::CFG_TIME_STEP) sb.time_step = value;
    else sb.zero_thr = value[15:0];
  endtask

  initial begin
    pair_item_t it, base;
    pair_item_t directed[$];
    logic [31:0] step_set[5];
    logic [31:0] thr_set[5];
    int burst_left;
    int timer;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = sobb_pkg::CFG_TIME_STEP;
    cfg_data = '0;
    boxes_if.valid = 1'b0;
    boxes_if.a_position = '0; boxes_if.a_rotation = '0;
    boxes_if.a_center = '0; boxes_if.a_extent = '0;
    boxes_if.b_position = '0; boxes_if.b_rotation = '0;
    boxes_if.b_center = '0; boxes_if.b_extent = '0;
    boxes_if.relative_velocity = '0;
    result_if.ready = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // identity frames, overlapping unit boxes at rest
    base.a_pos = '0; base.b_pos = pack2(65536, 0);
    base.a_rot = pack2(65536, 0); base.b_rot = pack2(65536, 0);
    base.a_cen = '0; base.b_cen = '0;
    base.a_ext = pack2(65536, 65536); base.b_ext = pack2(65536, 65536);
    base.rel_vel = '0;
    directed = {directed, base};
    it = base; it.b_pos = pack2(65536 * 10, 0);              directed = {directed, it};
    it.rel_vel = pack2(-65536 * 600, 0);                     directed = {directed, it};
    it.rel_vel = pack2(65536 * 600, 0);                      directed = {directed, it};
    it = base; it.a_ext = '0;                                directed = {directed, it};
    it = base; it.a_ext = pack2(-65536, -65536);             directed = {directed, it};
    it = base; it.b_ext = pack2(-65536, 65536);              directed = {directed, it};
    it = base; it.rel_vel = pack2(1, -1);                    directed = {directed, it};
    it = base; it.rel_vel = 64'h8000_0000_8000_0000;         directed = {directed, it};
    it = base; it.rel_vel = 64'h7fff_ffff_7fff_ffff;         directed = {directed, it};
    it = base; it.a_ext = 64'h7fff_ffff_7fff_ffff;
    it.b_ext = 64'h7fff_ffff_7fff_ffff;                      directed = {directed, it};
    it = base; it.a_rot = 64'h7fff_ffff_8000_0000;
    it.b_rot = 64'h8000_0000_7fff_ffff;                      directed = {directed, it};
    it = base; it.a_pos = 64'h8000_0000_8000_0000;
    it.b_pos = 64'h7fff_ffff_7fff_ffff;                      directed = {directed, it};
    it.a_rot = '0; it.b_rot = '0;                            directed = {directed, it};
    it = base; it.b_rot = pack2(0, 65536); it.a_cen = pack2(-65536 * 3, 65536);
    it.rel_vel = pack2(65536 * 120, -65536 * 40);            directed = {directed, it};
    it.a_pos = '1; it.a_rot = '1; it.a_cen = '1; it.a_ext = '1;
    it.b_pos = '1; it.b_rot = '1; it.b_cen = '1; it.b_ext = '1;
    it.rel_vel = '1;                                         directed = {directed, it};
    it.a_pos = '0; it.a_rot = '0; it.a_cen = '0; it.a_ext = '0;
    it.b_pos = '0; it.b_rot = '0; it.b_cen = '0; it.b_ext = '0;
    it.rel_vel = '0;                                         directed = {directed, it};

    step_set = '{32'd1092, 32'd65536, 32'd0, 32'hffff_ffff, 32'd4369};
    thr_set  = '{32'd1, 32'd0, 32'd65535, 32'd300, 32'd1};

    burst_left = 0;
    foreach (directed[i]) send_stream(directed[i], burst_left);

    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) begin
        write_reg(sobb_pkg::CFG_TIME_STEP, step_set[ph]);
        write_reg(sobb_pkg::CFG_ZERO_THR, thr_set[ph]);
      end
      repeat (165) begin
        if ($urandom_range(0, 4) == 0) send_stream(noise_pair(), burst_left);
        else send_stream(scene_pair(), burst_left);
      end
    end
    boxes_if.valid <= 1'b0;

    timer = 0;
    while (sb.hit_q.size() != 0 && timer < WATCHDOG_LIMIT) begin
      @(posedge clk);
      timer++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.hit_q.size() == 0 && sb.n_err == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
